[hw/rtl/rnc_pkg.sv]
// rnc_pkg: shared types, constants and word layouts for the navigation controller.
// No dependencies; used by every module under hw/rtl.

package rnc_pkg;

   // scan geometry
   localparam int NUM_BEAMS          = 360;
   localparam int LEFT_SECTOR_END    = 17;
   localparam int RIGHT_SECTOR_START = 343;

   // field widths
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 9;
   localparam int DIST_W   = 16;
   localparam int PIX_W    = 12;
   localparam int RATE_W   = 12;
   localparam int TICK_W   = 32;
   localparam int ANG_W    = 13;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;

   // alignment math: e2 = 2*center - width, |e2| fits MAG_W, dividend = |e2| * max_rate
   localparam int E2_W      = PIX_W + 2;
   localparam int MAG_W     = PIX_W + 1;
   localparam int DVD_W     = MAG_W + RATE_W;
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // request word layout, lowest bit up
   localparam int RQ_IDX_LSB  = 0;
   localparam int RQ_RNG_LSB  = RQ_IDX_LSB + IDX_W;
   localparam int RQ_SEEN_LSB = RQ_RNG_LSB + DIST_W;
   localparam int RQ_ODST_LSB = RQ_SEEN_LSB + 1;
   localparam int RQ_OCX_LSB  = RQ_ODST_LSB + DIST_W;
   localparam int RQ_OFW_LSB  = RQ_OCX_LSB + PIX_W;

   // reset values of the registers
   localparam logic [DIST_W-1:0] SAFE_DIST_RST   = 16'd500;
   localparam logic [PIX_W-1:0]  ALIGN_THR_RST   = 12'd20;
   localparam logic [DIST_W-1:0] TARGET_DIST_RST = 16'd500;
   localparam logic [RATE_W-1:0] MAX_TURN_RST    = 12'd500;
   localparam logic [RATE_W-1:0] SPIN_RATE_RST   = 12'd300;
   localparam logic [RATE_W-1:0] CRUISE_RST      = 12'd500;
   localparam logic [TICK_W-1:0] SEARCH_TICKS_RST    = 32'd5000;
   localparam logic [TICK_W-1:0] CELEBRATE_TICKS_RST = 32'd4000;

   typedef enum logic [MODE_W-1:0] {
      MODE_FWD = 2'd0,
      MODE_ROT = 2'd1,
      MODE_ALN = 2'd2,
      MODE_APP = 2'd3
   } mode_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEAM   = 2'd0,
      CMD_CAMERA = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAFE_DIST   = 3'd0,
      CSR_ALIGN_THR   = 3'd1,
      CSR_TARGET_DIST = 3'd2,
      CSR_MAX_TURN    = 3'd3,
      CSR_SPIN_RATE   = 3'd4,
      CSR_CRUISE      = 3'd5,
      CSR_SEARCH_TICKS    = 3'd6,
      CSR_CELEBRATE_TICKS = 3'd7
   } csr_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request word
      logic commit;    // apply the evaluated state update (and result, if any)
      logic mul_load;  // register |e2| * max_rate into the divider
      logic div_step;  // one restoring-division step
      logic fin_emit;  // write the clamped alignment result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic emits;
      logic slot_free;
   } dp_sts_type;

endpackage

[hw/rtl/reactive_navigation_controller.sv]
// reactive_navigation_controller: top level, joins rnc_ctrl and rnc_dp.
// Depends on rnc_pkg, rnc_ctrl, rnc_dp.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tdata 72b, tuser 2b (cmd)
//   rsp_     out        rsp_tvalid/rsp_tready  tdata 32b
//   csr_     in         csr_we                 csr_index 3b, csr_wdata 32b
//
// Beam, camera and tick words are accepted, then evaluated and committed.
// The scan-end word in align mode with a nonzero width and an error outside the threshold
// goes through load, the bit-serial divider (25 steps, one quotient bit per cycle) and finish.
// A word that yields a result waits in evaluation (after a divide, in finish) until the result
// register is free; req_tready rises again only after that. Reset is synchronous and restores
// all registers, state and the empty result register.

module reactive_navigation_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: beam_index[8:0], beam_range_mm[24:9], object_seen[25],
   //        object_distance_mm[41:26], obj_pos_px[53:42], frame_width[65:54], zeros
   input  logic [rnc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: cmd[1:0]
   input  logic [rnc_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: linear_speed[11:0], angular_speed[24:12], mode_now[26:25], zeros
   output logic [rnc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [rnc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rnc_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   rnc_pkg::dp_cmd_type cmd;
   rnc_pkg::dp_sts_type sts;

   rnc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rnc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[hw/rtl/rnc_ctrl.sv]
// rnc_ctrl: sequencer for the navigation controller (accept, evaluate, divide, finish).
// Depends on rnc_pkg.

module rnc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rnc_pkg::dp_sts_type   sts,
   output rnc_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [rnc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic div_last;

   assign div_last = (cnt_ff == rnc_pkg::DIV_CNT_W'(rnc_pkg::DIV_STEPS - 1));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.need_div) begin
               // beam flags land now; the turn result follows the divide
               cmd.commit   = 1'b1;
               cmd.mul_load = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else if (!sts.emits || sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.slot_free) begin
               cmd.fin_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hw/rtl/rnc_dp.sv]
// rnc_dp: registers, navigation state, mode rules, divider and result register.
// Depends on rnc_pkg; driven by rnc_ctrl.

module rnc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rnc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rnc_pkg::CSR_DAT_W-1:0]       csr_wdata,
   input  logic [rnc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [rnc_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rnc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  rnc_pkg::dp_cmd_type                 cmd,
   output rnc_pkg::dp_sts_type                 sts
);

   localparam int IW = rnc_pkg::IDX_W;
   localparam int DW = rnc_pkg::DIST_W;
   localparam int PW = rnc_pkg::PIX_W;
   localparam int RW = rnc_pkg::RATE_W;
   localparam int TW = rnc_pkg::TICK_W;
   localparam int AW = rnc_pkg::ANG_W;

   // configuration
   logic [DW-1:0] safe_ff, tgt_ff;
   logic [PW-1:0] thr_ff;
   logic [RW-1:0] mx_ff, spin_ff, cruise_ff;
   logic [TW-1:0] search_ff, celeb_ff;

   // captured request
   rnc_pkg::cmd_type kind_ff;
   logic [IW-1:0] idx_ff;
   logic [DW-1:0] rng_ff, odist_ff;
   logic          oseen_ff;
   logic [PW-1:0] ocx_ff, ofw_ff;

   // navigation state
   rnc_pkg::mode_type mode_ff, mode_in;
   logic turn_pos_ff, turn_pos_in;
   logic lhit_ff, lhit_in, fhit_ff, fhit_in, rhit_ff, rhit_in;
   logic tseen_ff, tseen_in;
   logic [DW-1:0] tdist_ff, tdist_in;
   logic [PW-1:0] tcen_ff, tcen_in, twid_ff, twid_in;
   logic init_spin_ff, init_spin_in, spin_tgt_ff, spin_tgt_in;
   logic run_ff, run_in;
   logic [TW-1:0] ticks_ff, ticks_in;

   // divider
   logic [rnc_pkg::DVD_W-1:0] dq_ff, dq_in;
   logic [PW-1:0]             rem_ff, rem_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rnc_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // alignment error
   logic signed [rnc_pkg::E2_W-1:0] e2;
   logic [rnc_pkg::E2_W-1:0]        e2_abs;
   logic [rnc_pkg::MAG_W-1:0]       mag;
   logic                            e2_neg;
   logic signed [AW-1:0]            spin_val;

   // rule evaluation results
   logic                 emit, need_div, hit, in_left, in_right, clear_v, left_only;
   logic [RW-1:0]        o_lin;
   logic signed [AW-1:0] o_ang;

   // finish path
   logic [PW:0]             rem_sh;
   logic                    ge;
   logic [RW-1:0]           turn_mag;
   logic signed [AW-1:0]    fin_ang;

   assign e2     = $signed({1'b0, tcen_ff, 1'b0}) - $signed({2'b00, twid_ff});
   assign e2_neg = e2[rnc_pkg::E2_W-1];
   assign e2_abs = e2_neg ? rnc_pkg::E2_W'(-e2) : rnc_pkg::E2_W'(e2);
   assign mag    = e2_abs[rnc_pkg::MAG_W-1:0];
   assign spin_val = turn_pos_ff ? $signed({1'b0, spin_ff}) : -$signed({1'b0, spin_ff});

   // one item's effect on the state, evaluated from the captured word
   always_comb begin
      mode_in      = mode_ff;
      turn_pos_in  = turn_pos_ff;
      lhit_in      = lhit_ff;
      fhit_in      = fhit_ff;
      rhit_in      = rhit_ff;
      tseen_in     = tseen_ff;
      tdist_in     = tdist_ff;
      tcen_in      = tcen_ff;
      twid_in      = twid_ff;
      init_spin_in = init_spin_ff;
      spin_tgt_in  = spin_tgt_ff;
      run_in       = run_ff;
      ticks_in     = ticks_ff;
      emit         = 1'b0;
      need_div     = 1'b0;
      o_lin        = '0;
      o_ang        = '0;
      hit          = rng_ff < safe_ff;
      in_left      = int'(idx_ff) <= rnc_pkg::LEFT_SECTOR_END;
      in_right     = int'(idx_ff) >= rnc_pkg::RIGHT_SECTOR_START;
      clear_v      = 1'b0;
      left_only    = 1'b0;
      case (kind_ff)
         rnc_pkg::CMD_BEAM: begin
            if (int'(idx_ff) < rnc_pkg::NUM_BEAMS) begin
               if (idx_ff == '0) begin
                  lhit_in = 1'b0;
                  fhit_in = 1'b0;
                  rhit_in = 1'b0;
               end
               if (in_left && hit) lhit_in = 1'b1;
               if (in_right && hit) rhit_in = 1'b1;
               if (!in_left && !in_right && hit) fhit_in = 1'b1;
               clear_v   = !lhit_in && !fhit_in && !rhit_in;
               left_only = lhit_in && !fhit_in && !rhit_in;
               // end of scan: run the current mode's rule
               if (int'(idx_ff) == rnc_pkg::NUM_BEAMS - 1) begin
                  case (mode_ff)
                     rnc_pkg::MODE_FWD: begin
                        if (tseen_ff) begin
                           mode_in = rnc_pkg::MODE_ALN;
                        end else if (clear_v) begin
                           emit  = 1'b1;
                           o_lin = cruise_ff;
                        end else begin
                           turn_pos_in = !left_only;
                           mode_in     = rnc_pkg::MODE_ROT;
                        end
                     end
                     rnc_pkg::MODE_ROT: begin
                        if (tseen_ff) begin
                           mode_in = rnc_pkg::MODE_ALN;
                        end else if (init_spin_ff) begin
                           if (!run_ff) begin
                              run_in   = 1'b1;
                              ticks_in = search_ff;
                           end
                           emit  = 1'b1;
                           o_ang = spin_val;
                        end else if (clear_v) begin
                           mode_in = rnc_pkg::MODE_FWD;
                        end else begin
                           emit  = 1'b1;
                           o_ang = spin_val;
                        end
                     end
                     rnc_pkg::MODE_ALN: begin
                        if (!tseen_ff) begin
                           mode_in = rnc_pkg::MODE_FWD;
                        end else if (mag < {thr_ff, 1'b0}) begin
                           mode_in = rnc_pkg::MODE_APP;
                        end else if (twid_ff == '0) begin
                           emit = 1'b1;
                           if (e2_neg) begin
                              o_ang = $signed({1'b0, mx_ff});
                           end else if (e2 != '0) begin
                              o_ang = -$signed({1'b0, mx_ff});
                           end
                        end else begin
                           need_div = 1'b1;
                        end
                     end
                     rnc_pkg::MODE_APP: begin
                        if (spin_tgt_ff) begin
                           emit  = 1'b1;
                           o_ang = spin_val;
                        end else if (!tseen_ff) begin
                           mode_in = rnc_pkg::MODE_FWD;
                        end else if (tdist_ff <= tgt_ff) begin
                           if (!run_ff) begin
                              spin_tgt_in = 1'b1;
                              run_in      = 1'b1;
                              ticks_in    = celeb_ff;
                           end
                           emit  = 1'b1;
                           o_ang = spin_val;
                        end else begin
                           emit  = 1'b1;
                           o_lin = cruise_ff;
                        end
                     end
                     default: begin
                        mode_in = mode_ff;
                     end
                  endcase
               end
            end
         end
         rnc_pkg::CMD_CAMERA: begin
            tseen_in = oseen_ff;
            tdist_in = odist_ff;
            tcen_in  = ocx_ff;
            twid_in  = ofw_ff;
            if (oseen_ff && (mode_ff == rnc_pkg::MODE_FWD || mode_ff == rnc_pkg::MODE_ROT)) begin
               mode_in = rnc_pkg::MODE_ALN;
            end
         end
         rnc_pkg::CMD_TICK: begin
            if (run_ff) begin
               if (ticks_ff > TW'(1)) begin
                  ticks_in = ticks_ff - 1'b1;
               end else begin
                  run_in   = 1'b0;
                  ticks_in = '0;
                  if (mode_ff == rnc_pkg::MODE_ROT) begin
                     init_spin_in = 1'b0;
                  end else if (mode_ff == rnc_pkg::MODE_APP) begin
                     spin_tgt_in = 1'b0;
                     mode_in     = rnc_pkg::MODE_FWD;
                  end
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      // leaving a mode drops any pending timer
      if (mode_in != mode_ff) begin
         run_in   = 1'b0;
         ticks_in = '0;
         if (mode_in == rnc_pkg::MODE_ROT) init_spin_in = 1'b1;
         if (mode_in == rnc_pkg::MODE_APP) spin_tgt_in = 1'b0;
      end
   end

   // restoring division step, and the clamped result it feeds
   assign rem_sh = {rem_ff, dq_ff[rnc_pkg::DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, twid_ff};
   always_comb begin
      dq_in  = {dq_ff[rnc_pkg::DVD_W-2:0], ge};
      rem_in = ge ? PW'(rem_sh - {1'b0, twid_ff}) : rem_sh[PW-1:0];
      if (cmd.mul_load) begin
         dq_in  = rnc_pkg::DVD_W'({{RW{1'b0}}, mag} * {{rnc_pkg::MAG_W{1'b0}}, mx_ff});
         rem_in = '0;
      end
   end

   assign turn_mag = (dq_ff > rnc_pkg::DVD_W'(mx_ff)) ? mx_ff : dq_ff[RW-1:0];
   assign fin_ang  = e2_neg ? $signed({1'b0, turn_mag}) : -$signed({1'b0, turn_mag});

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.commit && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, mode_in, o_ang, o_lin};
      end else if (cmd.fin_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, mode_ff, fin_ang, {RW{1'b0}}};
      end
   end

   assign sts.need_div  = need_div;
   assign sts.emits     = emit;
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_ff   <= rnc_pkg::SAFE_DIST_RST;
         thr_ff    <= rnc_pkg::ALIGN_THR_RST;
         tgt_ff    <= rnc_pkg::TARGET_DIST_RST;
         mx_ff     <= rnc_pkg::MAX_TURN_RST;
         spin_ff   <= rnc_pkg::SPIN_RATE_RST;
         cruise_ff <= rnc_pkg::CRUISE_RST;
         search_ff <= rnc_pkg::SEARCH_TICKS_RST;
         celeb_ff  <= rnc_pkg::CELEBRATE_TICKS_RST;
      end else if (csr_we) begin
         case (rnc_pkg::csr_idx_type'(csr_index))
            rnc_pkg::CSR_SAFE_DIST:       safe_ff   <= csr_wdata[DW-1:0];
            rnc_pkg::CSR_ALIGN_THR:       thr_ff    <= csr_wdata[PW-1:0];
            rnc_pkg::CSR_TARGET_DIST:     tgt_ff    <= csr_wdata[DW-1:0];
            rnc_pkg::CSR_MAX_TURN:        mx_ff     <= csr_wdata[RW-1:0];
            rnc_pkg::CSR_SPIN_RATE:       spin_ff   <= csr_wdata[RW-1:0];
            rnc_pkg::CSR_CRUISE:          cruise_ff <= csr_wdata[RW-1:0];
            rnc_pkg::CSR_SEARCH_TICKS:    search_ff <= csr_wdata[TW-1:0];
            rnc_pkg::CSR_CELEBRATE_TICKS: celeb_ff  <= csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture, divider and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= rnc_pkg::cmd_type'(req_tuser);
         idx_ff   <= req_tdata[rnc_pkg::RQ_IDX_LSB +: IW];
         rng_ff   <= req_tdata[rnc_pkg::RQ_RNG_LSB +: DW];
         oseen_ff <= req_tdata[rnc_pkg::RQ_SEEN_LSB];
         odist_ff <= req_tdata[rnc_pkg::RQ_ODST_LSB +: DW];
         ocx_ff   <= req_tdata[rnc_pkg::RQ_OCX_LSB +: PW];
         ofw_ff   <= req_tdata[rnc_pkg::RQ_OFW_LSB +: PW];
      end
      if (cmd.mul_load || cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // navigation state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rnc_pkg::MODE_FWD;
         turn_pos_ff  <= 1'b1;
         lhit_ff      <= 1'b0;
         fhit_ff      <= 1'b0;
         rhit_ff      <= 1'b0;
         tseen_ff     <= 1'b0;
         tdist_ff     <= '0;
         tcen_ff      <= '0;
         twid_ff      <= '0;
         init_spin_ff <= 1'b1;
         spin_tgt_ff  <= 1'b0;
         run_ff       <= 1'b0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            mode_ff      <= mode_in;
            turn_pos_ff  <= turn_pos_in;
            lhit_ff      <= lhit_in;
            fhit_ff      <= fhit_in;
            rhit_ff      <= rhit_in;
            tseen_ff     <= tseen_in;
            tdist_ff     <= tdist_in;
            tcen_ff      <= tcen_in;
            twid_ff      <= twid_in;
            init_spin_ff <= init_spin_in;
            spin_tgt_ff  <= spin_tgt_in;
            run_ff       <= run_in;
            ticks_ff     <= ticks_in;
         end
      end
   end

endmodule

[hw/rtl/rnc_checker.sv]
// rnc_checker: port-level assertions for the navigation controller, bound to the top.
// Depends on rnc_pkg and reactive_navigation_controller.

module rnc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [rnc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input logic [rnc_pkg::CMD_W-1:0]           req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rnc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input logic                                csr_we,
   input logic [rnc_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [rnc_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // one word in flight: no accept in the cycle right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while previous word in flight");

   // a command never drives and turns at once
   a_drive_or_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:0] != 12'd0) |-> rsp_tdata[24:12] == 13'd0)
      else $error("linear and angular speed both nonzero");

   // turn magnitude stays within 12 bits, padding stays zero
   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:12] != 13'h1000) && (rsp_tdata[31:27] == 5'd0))
      else $error("rsp word out of range");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind reactive_navigation_controller rnc_checker u_rnc_checker (.*);

[dv/reactive_navigation_controller_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for reactive_navigation_controller: drives beam, camera and tick
// words, predicts every motion command and compares it. Depends on rnc_pkg and the RTL.

module reactive_navigation_controller_test;
   import rnc_pkg::*;

   localparam int SETTLE_CYCLES = 40;      // longer than the align divide
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASE_WORDS   = 68;

   typedef enum int {OBS_CLEAR, OBS_LEFT, OBS_RIGHT, OBS_FRONT} obstacle_type;

   typedef struct {
      logic [RATE_W-1:0] lin;
      logic [ANG_W-1:0]  ang;
      mode_type          mode;
   } motion_word_type;

   class nav_scoreboard;
      logic [DIST_W-1:0] safe_mm, target_mm;
      logic [PIX_W-1:0]  thr_px;
      logic [RATE_W-1:0] max_rate, spin_rate, cruise;
      logic [TICK_W-1:0] search_ticks, celebrate_ticks;
      mode_type          mode;
      bit                turn_pos, left_hit, front_hit, right_hit, tgt_seen;
      logic [DIST_W-1:0] tgt_dist;
      logic [PIX_W-1:0]  tgt_cx, tgt_w;
      bit                initial_spin, celebrating, timer_on;
      logic [TICK_W-1:0] ticks_left;
      motion_word_type   expected_motion[$];
      int                errors;
      int                checked;

      function new();
         safe_mm = SAFE_DIST_RST;
         thr_px = ALIGN_THR_RST;
         target_mm = TARGET_DIST_RST;
         max_rate = MAX_TURN_RST;
         spin_rate = SPIN_RATE_RST;
         cruise = CRUISE_RST;
         search_ticks = SEARCH_TICKS_RST;
         celebrate_ticks = CELEBRATE_TICKS_RST;
         mode = MODE_FWD;
         turn_pos = 1'b1;
         left_hit = 1'b0;
         front_hit = 1'b0;
         right_hit = 1'b0;
         tgt_seen = 1'b0;
         tgt_dist = '0;
         tgt_cx = '0;
         tgt_w = '0;
         initial_spin = 1'b1;
         celebrating = 1'b0;
         timer_on = 1'b0;
         ticks_left = '0;
         errors = 0;
         checked = 0;
      endfunction

      function void set_register(csr_idx_type idx, logic [CSR_DAT_W-1:0] v);
         case (idx)
            CSR_SAFE_DIST:       safe_mm = v[DIST_W-1:0];
            CSR_ALIGN_THR:       thr_px = v[PIX_W-1:0];
            CSR_TARGET_DIST:     target_mm = v[DIST_W-1:0];
            CSR_MAX_TURN:        max_rate = v[RATE_W-1:0];
            CSR_SPIN_RATE:       spin_rate = v[RATE_W-1:0];
            CSR_CRUISE:          cruise = v[RATE_W-1:0];
            CSR_SEARCH_TICKS:    search_ticks = v;
            CSR_CELEBRATE_TICKS: celebrate_ticks = v;
            default: ;
         endcase
      endfunction

      // a pending timer dies with the mode it was armed in
      function void enter_mode(mode_type m);
         if (m != mode) begin
            timer_on = 1'b0;
            ticks_left = '0;
         end
         if (m == MODE_ROT && mode != MODE_ROT) initial_spin = 1'b1;
         if (m == MODE_APP && mode != MODE_APP) celebrating = 1'b0;
         mode = m;
      endfunction

      function void drive_motion(logic [RATE_W-1:0] lin, logic [ANG_W-1:0] ang);
         motion_word_type w;
         w.lin = lin;
         w.ang = ang;
         w.mode = mode;
         expected_motion.push_back(w);
      endfunction

      function logic [ANG_W-1:0] spin_turn();
         logic [ANG_W-1:0] s;
         s = {1'b0, spin_rate};
         return turn_pos ? s : -s;
      endfunction

      function obstacle_type obstacle();
         if (left_hit && !right_hit && !front_hit) return OBS_LEFT;
         if (!left_hit && right_hit && !front_hit) return OBS_RIGHT;
         if (front_hit || (left_hit && right_hit)) return OBS_FRONT;
         return OBS_CLEAR;
      endfunction

      function void finish_scan();
         longint cx, w, thr, e2, mag, mx, turn, neg;
         obstacle_type obs;
         case (mode)
            MODE_FWD: begin
               if (tgt_seen) begin
                  enter_mode(MODE_ALN);
               end else begin
                  obs = obstacle();
                  if (obs == OBS_CLEAR) begin
                     drive_motion(cruise, '0);
                  end else begin
                     turn_pos = (obs != OBS_LEFT);
                     enter_mode(MODE_ROT);
                  end
               end
            end
            MODE_ROT: begin
               if (tgt_seen) begin
                  enter_mode(MODE_ALN);
               end else if (initial_spin) begin
                  if (!timer_on) begin
                     timer_on = 1'b1;
                     ticks_left = search_ticks;
                  end
                  drive_motion('0, spin_turn());
               end else if (obstacle() == OBS_CLEAR) begin
                  enter_mode(MODE_FWD);
               end else begin
                  drive_motion('0, spin_turn());
               end
            end
            MODE_ALN: begin
               if (!tgt_seen) begin
                  enter_mode(MODE_FWD);
               end else begin
                  cx = tgt_cx;
                  w = tgt_w;
                  thr = thr_px;
                  mx = max_rate;
                  e2 = 2 * cx - w;            // doubled pixel error
                  mag = (e2 < 0) ? -e2 : e2;
                  if (mag < 2 * thr) begin
                     enter_mode(MODE_APP);
                  end else begin
                     if (w == 0) begin
                        turn = (e2 > 0) ? mx : ((e2 < 0) ? -mx : 0);
                     end else begin
                        turn = (mag * mx) / w;
                        if (e2 < 0) turn = -turn;
                        if (turn > mx) turn = mx;
                        if (turn < -mx) turn = -mx;
                     end
                     neg = -turn;
                     drive_motion('0, neg[ANG_W-1:0]);
                  end
               end
            end
            default: begin
               if (celebrating) begin
                  drive_motion('0, spin_turn());
               end else if (!tgt_seen) begin
                  enter_mode(MODE_FWD);
               end else if (tgt_dist <= target_mm) begin
                  if (!timer_on) begin
                     celebrating = 1'b1;
                     timer_on = 1'b1;
                     ticks_left = celebrate_ticks;
                  end
                  drive_motion('0, spin_turn());
               end else begin
                  drive_motion(cruise, '0);
               end
            end
         endcase
      endfunction

      function void note_word(logic [CMD_W-1:0] user, logic [REQ_DATA_W-1:0] data);
         int idx;
         bit hit;
         case (cmd_type'(user))
            CMD_BEAM: begin
               idx = int'(data[RQ_IDX_LSB +: IDX_W]);
               if (idx < NUM_BEAMS) begin
                  if (idx == 0) begin
                     left_hit = 1'b0;
                     front_hit = 1'b0;
                     right_hit = 1'b0;
                  end
                  hit = data[RQ_RNG_LSB +: DIST_W] < safe_mm;
                  if (hit && idx <= LEFT_SECTOR_END) left_hit = 1'b1;
                  if (hit && idx >= RIGHT_SECTOR_START) right_hit = 1'b1;
                  if (hit && idx > LEFT_SECTOR_END && idx < RIGHT_SECTOR_START)
                     front_hit = 1'b1;
                  if (idx == NUM_BEAMS - 1) finish_scan();
               end
            end
            CMD_CAMERA: begin
               tgt_seen = data[RQ_SEEN_LSB];
               tgt_dist = data[RQ_ODST_LSB +: DIST_W];
               tgt_cx = data[RQ_OCX_LSB +: PIX_W];
               tgt_w = data[RQ_OFW_LSB +: PIX_W];
               if (tgt_seen && (mode == MODE_FWD || mode == MODE_ROT)) enter_mode(MODE_ALN);
            end
            CMD_TICK: begin
               if (timer_on) begin
                  if (ticks_left > 1) begin
                     ticks_left = ticks_left - 1'b1;
                  end else begin
                     timer_on = 1'b0;
                     ticks_left = '0;
                     if (mode == MODE_ROT) begin
                        initial_spin = 1'b0;
                     end else if (mode == MODE_APP) begin
                        celebrating = 1'b0;
                        enter_mode(MODE_FWD);
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] d);
         motion_word_type w;
         logic [RATE_W-1:0] lin;
         logic [ANG_W-1:0]  ang;
         logic [MODE_W-1:0] md;
         lin = d[0 +: RATE_W];
         ang = d[RATE_W +: ANG_W];
         md = d[RATE_W + ANG_W +: MODE_W];
         if (expected_motion.size() == 0) begin
            $error("motion command with none expected: %h", d);
            errors++;
            return;
         end
         w = expected_motion.pop_front();
         checked++;
         if (lin !== w.lin) begin
            $error("linear_speed: expected %0d, got %0d", w.lin, lin);
            errors++;
         end
         if (ang !== w.ang) begin
            $error("angular_speed: expected %0d, got %0d", $signed(w.ang), $signed(ang));
            errors++;
         end
         if (md !== w.mode) begin
            $error("mode_now: expected %0d, got %0d", w.mode, md);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DAT_W-1:0]   csr_wdata = '0;

   nav_scoreboard board;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int useful_words = 0;
   int sent_words = 0;
   int settings_used = 0;

   reactive_navigation_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d commands still expected",
                  cycle_count, board.expected_motion.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] beam_word(logic [IDX_W-1:0] idx,
                                                       logic [DIST_W-1:0] rng);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[RQ_IDX_LSB +: IDX_W] = idx;
      d[RQ_RNG_LSB +: DIST_W] = rng;
      return d;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] camera_word(logic seen, logic [DIST_W-1:0] obj_mm,
                                                         logic [PIX_W-1:0] cx,
                                                         logic [PIX_W-1:0] w);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[RQ_SEEN_LSB] = seen;
      d[RQ_ODST_LSB +: DIST_W] = obj_mm;
      d[RQ_OCX_LSB +: PIX_W] = cx;
      d[RQ_OFW_LSB +: PIX_W] = w;
      return d;
   endfunction

   // ranges cluster around the blocking threshold
   function automatic logic [DIST_W-1:0] pick_range();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return board.safe_mm - 1'b1;
         3: return board.safe_mm;
         default: return DIST_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_word(cmd_type c, logic [REQ_DATA_W-1:0] d);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= c;
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic send_beam(int idx, logic [DIST_W-1:0] rng);
      send_word(CMD_BEAM, beam_word(IDX_W'(idx), rng));
   endtask

   task automatic send_camera_word(logic seen, int obj_mm, int cx, int w);
      send_word(CMD_CAMERA, camera_word(seen, DIST_W'(obj_mm), PIX_W'(cx), PIX_W'(w)));
   endtask

   task automatic csr_write(csr_idx_type idx, logic [CSR_DAT_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_register(idx, v);
   endtask

   // hold off the sender until every command is out and the block is quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.expected_motion.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(int phase);
      logic [CSR_DAT_W-1:0] v [8];
      case (phase)
         0: v = '{500, 20, 500, 500, 300, 500, 3, 2};
         1: v = '{16'hFFFF, 12'hFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0, 0};
         2: v = '{0, 0, 0, 0, 0, 0, 1, 1};
         default: begin
            v[0] = $urandom_range(0, 1500);
            v[1] = $urandom_range(0, 40);
            v[2] = $urandom_range(0, 1500);
            v[3] = $urandom_range(0, 4095);
            v[4] = $urandom_range(0, 4095);
            v[5] = $urandom_range(0, 4095);
            v[6] = (phase == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 6);
            v[7] = (phase == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 6);
         end
      endcase
      for (int i = 0; i < 8; i++) csr_write(csr_idx_type'(i), v[i]);
      settings_used++;
   endtask

   // scan start, a few beams anywhere, then the scan-end beam
   task automatic run_scan();
      int n;
      int idx;
      send_beam(0, pick_range());
      n = $urandom_range(0, 4);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0: idx = LEFT_SECTOR_END;
            1: idx = LEFT_SECTOR_END + 1;
            2: idx = RIGHT_SECTOR_START - 1;
            3: idx = RIGHT_SECTOR_START;
            default: idx = $urandom_range(1, NUM_BEAMS - 2);
         endcase
         send_beam(idx, pick_range());
      end
      send_beam(NUM_BEAMS - 1, pick_range());
      useful_words += n + 2;
   endtask

   task automatic send_camera();
      logic seen;
      int w, cx, obj_mm;
      seen = ($urandom_range(0, 9) < 6);
      case ($urandom_range(0, 3))
         0: w = 0;
         1: w = 640;
         default: w = $urandom_range(0, 4095);
      endcase
      // near center often enough to reach approach
      if ($urandom_range(0, 1) == 0) cx = w / 2 + $urandom_range(0, 8) - 4;
      else cx = $urandom_range(0, 4095);
      case ($urandom_range(0, 3))
         0: obj_mm = board.target_mm;
         1: obj_mm = board.target_mm + 1;
         2: obj_mm = 0;
         default: obj_mm = $urandom_range(0, 65535);
      endcase
      send_camera_word(seen, obj_mm, cx, w);
      useful_words++;
   endtask

   task automatic send_ticks();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_word(CMD_TICK, '0);
      useful_words += n;
   endtask

   task automatic send_noise();
      logic [REQ_DATA_W-1:0] d;
      case ($urandom_range(0, 3))
         0: begin
            d = '0;
            d[31:0] = $urandom;
            d[63:32] = $urandom;
            d[65:64] = 2'($urandom_range(0, 3));
            send_word(CMD_NONE, d);
         end
         1: send_beam($urandom_range(NUM_BEAMS, 511), pick_range());
         2: begin
            send_beam($urandom_range(1, NUM_BEAMS - 2), pick_range());
            useful_words++;
         end
         default: begin
            // scan end without a scan start keeps the old flags
            send_beam(NUM_BEAMS - 1, pick_range());
            useful_words++;
         end
      endcase
   endtask

   initial begin
      int goal;
      int pick;
      board = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: short timers so both timed spins expire
      csr_write(CSR_SEARCH_TICKS, 2);
      csr_write(CSR_CELEBRATE_TICKS, 1);
      settings_used++;
      send_beam(0, 0);                        // left only -> rotate, turn negative
      send_beam(NUM_BEAMS - 1, '1);
      send_beam(NUM_BEAMS - 1, '1);           // initial spin, timer armed
      send_word(CMD_TICK, '0);
      send_word(CMD_TICK, '0);                // initial spin over
      send_beam(0, '1);
      send_beam(180, 100);                    // front blocked -> keep spinning
      send_beam(NUM_BEAMS - 1, '1);
      send_beam(0, '1);
      send_beam(NUM_BEAMS - 1, '1);           // clear -> forward
      send_beam(NUM_BEAMS - 1, '1);           // cruise
      send_beam(400, 0);                      // out-of-range index
      send_word(CMD_NONE, '0);
      send_camera_word(1'b1, 1000, 1000, 640);
      send_beam(NUM_BEAMS - 1, '1);           // align, clamped turn
      send_camera_word(1'b1, 1000, 320, 640);
      send_beam(NUM_BEAMS - 1, '1);           // centered -> approach
      send_beam(NUM_BEAMS - 1, '1);           // far -> cruise
      send_camera_word(1'b1, 400, 320, 640);
      send_beam(NUM_BEAMS - 1, '1);           // reached -> celebration spin
      send_word(CMD_TICK, '0);                // spin over -> forward
      send_camera_word(1'b1, 0, 4095, 0);
      send_beam(NUM_BEAMS - 1, '1);           // zero width -> full-scale turn
      send_camera_word(1'b0, 0, 0, 0);
      send_beam(NUM_BEAMS - 1, '1);           // target lost -> forward
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 85;
         end else if (phase < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_settings(phase);
         goal = useful_words + PHASE_WORDS;
         while (useful_words < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) run_scan();
            else if (pick < 70) send_camera();
            else if (pick < 84) send_ticks();
            else if (pick < 97) send_noise();
            else settle();
         end
         settle();
      end

      $display("Summary: %0d request words over %0d register settings, %0d motion commands checked",
               sent_words, settings_used, board.checked);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
